FILE: rtl/stcf_pkg.sv
// Shared types and constants for the segment text cleanup filter.
// No dependencies; used by segment_text_cleanup_filter_top.
package stcf_pkg;

    localparam int OUT_W      = 16;  // width of a cleaned code unit on the output side
    localparam int CFG_IDX_W  = 2;
    localparam int RES_DEPTH  = 5;   // most result beats one input beat can cause
    localparam int RES_CNT_W  = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REDUCE_LINE_BREAKS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REMOVE_TRADEMARK_TAGS = 2'd1;

    // characters
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_T_LO  = 8'h74;
    localparam logic [7:0] CH_T_UP  = 8'h54;
    localparam logic [7:0] CH_M_LO  = 8'h6D;
    localparam logic [7:0] CH_M_UP  = 8'h4D;

    typedef struct packed {
        logic [OUT_W-1:0] unit;
        logic             valid;
        logic             last;
    } res_t;

endpackage

FILE: rtl/segment_text_cleanup_filter_top.sv
// Segment text cleanup filter: line-break reduction then trademark tag removal.
// Depends on stcf_pkg (types, character constants, register indexes).
//
//  channel | signals                                  | direction | content
//  --------+------------------------------------------+-----------+---------------------------
//  s_      | s_tvalid s_tready s_tdata s_tlast        | in        | code unit, segment end
//  m_      | m_tvalid m_tready m_tdata m_tuser m_tlast| out       | cleaned unit, valid, end
//  cfg_    | cfg_valid cfg_ready cfg_index cfg_data   | in        | register writes
//
// One input beat is taken per cycle while the result buffer allows it. Both
// stages are evaluated in one pass of logic at acceptance, and the 0..5 result
// beats land in a small result buffer that drains one beat per cycle while
// m_tready is high; a new input beat is taken when the buffer is empty or its
// last beat leaves in the same cycle, so the next beat waits for the drain.
// Reset: both enables set, stage state cleared, buffer empty. Config is
// always ready.
module segment_text_cleanup_filter_top #(
    parameter int UNIT_WIDTH = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // s_tdata: [UNIT_WIDTH-1:0] code_unit, zero fill to whole bytes
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((UNIT_WIDTH+7)/8)*8-1:0]        s_tdata,
    input  logic                                   s_tlast,   // segment_last
    // m_tdata: [15:0] out_code_unit
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [stcf_pkg::OUT_W-1:0]             m_tdata,
    output logic                                   m_tuser,   // [0] out_valid
    output logic                                   m_tlast,   // out_last
    // configuration writes
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [stcf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic                                   cfg_data
);

    localparam int RD = stcf_pkg::RES_DEPTH;
    localparam int CW = stcf_pkg::RES_CNT_W;

    // config
    logic reduce_reg;
    logic remove_reg;

    // stage state
    logic                  held_lf_reg, held_lf_next;
    logic                  skip_reg, skip_next;
    logic [UNIT_WIDTH-1:0] win_reg [3];
    logic [UNIT_WIDTH-1:0] win_next [3];
    logic [1:0]            fill_reg, fill_next;

    // result buffer, entry 0 is on the output
    stcf_pkg::res_t res_reg [RD];
    stcf_pkg::res_t res_next [RD];
    logic [CW-1:0]  cnt_reg, cnt_next;

    logic [UNIT_WIDTH-1:0] unit_in;
    logic                  in_acc;
    logic                  out_acc;

    stcf_pkg::res_t        em [RD];
    logic [CW-1:0]         n;

    function automatic logic is_ch(input logic [UNIT_WIDTH-1:0] u, input logic [7:0] c);
        return u == UNIT_WIDTH'(c);
    endfunction

    function automatic logic tag_start(input logic [UNIT_WIDTH-1:0] a,
                                       input logic [UNIT_WIDTH-1:0] b,
                                       input logic [UNIT_WIDTH-1:0] c,
                                       input logic [UNIT_WIDTH-1:0] d);
        logic open_tag;
        logic close_tag;
        open_tag  = (is_ch(b, stcf_pkg::CH_T_LO) || is_ch(b, stcf_pkg::CH_T_UP))
                 && (is_ch(c, stcf_pkg::CH_M_LO) || is_ch(c, stcf_pkg::CH_M_UP))
                 && is_ch(d, stcf_pkg::CH_SPACE);
        close_tag = is_ch(b, stcf_pkg::CH_SLASH)
                 && (is_ch(c, stcf_pkg::CH_T_LO) || is_ch(c, stcf_pkg::CH_T_UP))
                 && (is_ch(d, stcf_pkg::CH_M_LO) || is_ch(d, stcf_pkg::CH_M_UP));
        return is_ch(a, stcf_pkg::CH_LT) && (open_tag || close_tag);
    endfunction

    assign unit_in   = s_tdata[UNIT_WIDTH-1:0];
    assign cfg_ready = 1'b1;
    assign out_acc   = m_tvalid && m_tready;
    // take a beat once the buffer is empty, or empties this cycle
    assign s_tready  = (cnt_reg == '0) || ((cnt_reg == CW'(1)) && m_tready);
    assign in_acc    = s_tvalid && s_tready;

    assign m_tvalid  = cnt_reg != '0;
    assign m_tdata   = res_reg[0].unit;
    assign m_tuser   = res_reg[0].valid;
    assign m_tlast   = res_reg[0].last;

    // One pass over both stages. Pass 0 carries a held LF (as a space),
    // pass 1 carries the incoming unit when stage one lets it through.
    always_comb
    begin
        logic                  act;
        logic [UNIT_WIDTH-1:0] u;
        skip_next = skip_reg;
        fill_next = fill_reg;
        for (int i = 0; i < 3; i++)
        begin
            win_next[i] = win_reg[i];
        end
        for (int i = 0; i < RD; i++)
        begin
            em[i] = '0;
        end
        n = '0;

        for (int k = 0; k < 2; k++)
        begin
            if (k == 0)
            begin
                act = held_lf_reg;
                u   = UNIT_WIDTH'(stcf_pkg::CH_SPACE);
            end
            else
            begin
                act = !reduce_reg
                   || (!is_ch(unit_in, stcf_pkg::CH_CR) && !is_ch(unit_in, stcf_pkg::CH_LF));
                u   = unit_in;
            end
            if (act)
            begin
                if (!remove_reg)
                begin
                    // flush pending units, then pass straight through
                    for (int i = 0; i < 3; i++)
                    begin
                        if (2'(i) < fill_next)
                        begin
                            em[n] = '{unit: stcf_pkg::OUT_W'(win_next[i]), valid: 1'b1,
                                      last: 1'b0};
                            n     = n + CW'(1);
                        end
                    end
                    fill_next = '0;
                    skip_next = 1'b0;
                    em[n] = '{unit: stcf_pkg::OUT_W'(u), valid: 1'b1, last: 1'b0};
                    n     = n + CW'(1);
                end
                else if (skip_next)
                begin
                    if (is_ch(u, stcf_pkg::CH_GT))
                    begin
                        skip_next = 1'b0;
                    end
                end
                else if (fill_next != 2'd3)
                begin
                    win_next[fill_next] = u;
                    fill_next           = fill_next + 2'd1;
                end
                else if (tag_start(win_next[0], win_next[1], win_next[2], u))
                begin
                    skip_next = 1'b1;
                    fill_next = '0;
                end
                else
                begin
                    em[n] = '{unit: stcf_pkg::OUT_W'(win_next[0]), valid: 1'b1, last: 1'b0};
                    n     = n + CW'(1);
                    win_next[0] = win_next[1];
                    win_next[1] = win_next[2];
                    win_next[2] = u;
                end
            end
        end

        held_lf_next = reduce_reg && is_ch(unit_in, stcf_pkg::CH_LF) && !s_tlast;

        if (s_tlast)
        begin
            // segment end: flush window, clear state, mark last beat
            for (int i = 0; i < 3; i++)
            begin
                if (2'(i) < fill_next)
                begin
                    em[n] = '{unit: stcf_pkg::OUT_W'(win_next[i]), valid: 1'b1, last: 1'b0};
                    n     = n + CW'(1);
                end
            end
            fill_next = '0;
            skip_next = 1'b0;
            if (n == '0)
            begin
                em[0] = '{unit: '0, valid: 1'b0, last: 1'b1};
                n     = CW'(1);
            end
            else
            begin
                em[n - CW'(1)].last = 1'b1;
            end
        end
    end

    // result buffer
    always_comb
    begin
        cnt_next = cnt_reg;
        for (int i = 0; i < RD; i++)
        begin
            res_next[i] = res_reg[i];
        end
        if (in_acc)
        begin
            for (int i = 0; i < RD; i++)
            begin
                res_next[i] = em[i];
            end
            cnt_next = n;
        end
        else if (out_acc)
        begin
            for (int i = 0; i < RD - 1; i++)
            begin
                res_next[i] = res_reg[i + 1];
            end
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reduce_reg  <= 1'b1;
            remove_reg  <= 1'b1;
            held_lf_reg <= 1'b0;
            skip_reg    <= 1'b0;
            fill_reg    <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    stcf_pkg::REG_REDUCE_LINE_BREAKS:    reduce_reg <= cfg_data;
                    stcf_pkg::REG_REMOVE_TRADEMARK_TAGS: remove_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (in_acc)
            begin
                held_lf_reg <= held_lf_next;
                skip_reg    <= skip_next;
                fill_reg    <= fill_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
        for (int i = 0; i < RD; i++)
        begin
            res_reg[i] <= res_next[i];
        end
    end

    // ---- assertions ----
    a_seg_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> (!held_lf_reg && !skip_reg && fill_reg == 2'd0))
        else $error("stage state not cleared at segment end");

    a_bare_marker: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tlast && m_tdata == '0))
        else $error("empty result beat is not a bare end marker");

    a_last_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (cnt_reg == CW'(1)))
        else $error("segment end beat is not the final buffered beat");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(RD))
        else $error("result buffer count out of range");

endmodule

FILE: bench/segment_text_cleanup_filter_top_tb.sv
// Self-checking bench for segment_text_cleanup_filter_top: directed rows, then random segments
// under several register settings, checked against an in-bench predictor or a hand-typed beat.
// Depends on stcf_pkg and the RTL of segment_text_cleanup_filter_top only.
module segment_text_cleanup_filter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int UW            = 16;
    localparam int DRAIN_CYCLES  = 10;     // buffer drain after the last due beat
    localparam int DRAIN_LIMIT   = 5000;   // cycles to wait for due beats before giving up
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 38;

    // register indexes the block does not decode; writes there must be ignored
    localparam logic [stcf_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [stcf_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    // characters widened to a full code unit
    localparam logic [UW-1:0] U_CR = 16'(stcf_pkg::CH_CR);
    localparam logic [UW-1:0] U_LF = 16'(stcf_pkg::CH_LF);
    localparam logic [UW-1:0] U_SP = 16'(stcf_pkg::CH_SPACE);
    localparam logic [UW-1:0] U_LT = 16'(stcf_pkg::CH_LT);
    localparam logic [UW-1:0] U_GT = 16'(stcf_pkg::CH_GT);
    localparam logic [UW-1:0] U_SL = 16'(stcf_pkg::CH_SLASH);
    localparam logic [UW-1:0] U_TL = 16'(stcf_pkg::CH_T_LO);
    localparam logic [UW-1:0] U_TU = 16'(stcf_pkg::CH_T_UP);
    localparam logic [UW-1:0] U_ML = 16'(stcf_pkg::CH_M_LO);
    localparam logic [UW-1:0] U_MU = 16'(stcf_pkg::CH_M_UP);

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [UW-1:0]                  s_tdata;   // [15:0] code_unit
    logic                           s_tlast;   // segment_last
    logic                           m_tvalid;
    logic                           m_tready;
    logic [stcf_pkg::OUT_W-1:0]     m_tdata;   // [15:0] out_code_unit
    logic                           m_tuser;   // [0] out_valid
    logic                           m_tlast;   // out_last
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [stcf_pkg::CFG_IDX_W-1:0] cfg_index;
    logic                           cfg_data;

    segment_text_cleanup_filter_top #(.UNIT_WIDTH(UW)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Cleanup predictor: its own copy of the registers and stage state.
    // ------------------------------------------------------------------
    bit             reduce_lb;      // line-break reduction enable
    bit             strip_tm;       // trademark tag removal enable
    bit             lf_held;        // inner LF waiting to go out as a space
    bit             in_tag;         // stage two is dropping units up to '>'
    logic [UW-1:0]  tag_win [3];    // units held back while looking for a tag opener
    int             tag_fill;       // valid entries in tag_win

    stcf_pkg::res_t step_beats[$];  // beats caused by the unit just predicted
    stcf_pkg::res_t due_beats[$];   // beats the block still owes, oldest first
    int             fail_count;

    function automatic void emit_unit(logic [UW-1:0] u);
        stcf_pkg::res_t b;
        b.unit  = u;
        b.valid = 1'b1;
        b.last  = 1'b0;
        step_beats.push_back(b);
    endfunction

    function automatic bit is_char(logic [UW-1:0] u, logic [UW-1:0] lo, logic [UW-1:0] up);
        return u == lo || u == up;
    endfunction

    // "<tm " or "</tm", letters in either case
    function automatic bit opens_tag(logic [UW-1:0] a, logic [UW-1:0] b,
                                     logic [UW-1:0] c, logic [UW-1:0] d);
        if (a != U_LT)
            return 1'b0;
        if (is_char(b, U_TL, U_TU) && is_char(c, U_ML, U_MU) && d == U_SP)
            return 1'b1;
        return b == U_SL && is_char(c, U_TL, U_TU) && is_char(d, U_ML, U_MU);
    endfunction

    function automatic void flush_win();
        for (int i = 0; i < tag_fill; i++)
            emit_unit(tag_win[i]);
        tag_fill = 0;
    endfunction

    function automatic void tag_stage(logic [UW-1:0] u);
        if (!strip_tm) begin
            // removal off: anything held goes out first, then straight through
            flush_win();
            in_tag = 1'b0;
            emit_unit(u);
        end
        else if (in_tag) begin
            if (u == U_GT)
                in_tag = 1'b0;
        end
        else if (tag_fill < 3) begin
            tag_win[tag_fill] = u;
            tag_fill++;
        end
        else if (opens_tag(tag_win[0], tag_win[1], tag_win[2], u)) begin
            in_tag   = 1'b1;
            tag_fill = 0;
        end
        else begin
            emit_unit(tag_win[0]);
            tag_win[0] = tag_win[1];
            tag_win[1] = tag_win[2];
            tag_win[2] = u;
        end
    endfunction

    // fills step_beats with what one accepted code unit causes
    function automatic void clean_unit(logic [UW-1:0] u, bit last);
        step_beats.delete();
        if (lf_held) begin
            lf_held = 1'b0;
            tag_stage(U_SP);
        end
        if (reduce_lb) begin
            if (u == U_LF) begin
                if (!last)
                    lf_held = 1'b1;
            end
            else if (u != U_CR)
                tag_stage(u);
        end
        else
            tag_stage(u);
        if (last) begin
            flush_win();
            in_tag  = 1'b0;
            lf_held = 1'b0;
            if (step_beats.size() == 0)
                step_beats.push_back('{unit: '0, valid: 1'b0, last: 1'b1});
            else
                step_beats[step_beats.size()-1].last = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Idle gaps: mostly none or short, now and then long. no_idle gives
    // whole phases of back-to-back beats on both sides.
    // ------------------------------------------------------------------
    bit no_idle;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 20);
    endfunction

    // Receiver: ready for one cycle, then a random stall.
    int ready_hold;

    always @(negedge clk)
    begin
        if (ready_hold > 0) begin
            ready_hold--;
            m_tready <= 1'b0;
        end
        else begin
            m_tready  <= 1'b1;
            ready_hold = pick_gap();
        end
    end

    // Result check: every beat taken is matched against the oldest due beat.
    always @(posedge clk)
    begin : beat_check
        stcf_pkg::res_t want;
        if (rst_n && m_tvalid && m_tready) begin
            if (due_beats.size() == 0) begin
                $error("result beat with nothing due: unit %h valid %b last %b",
                       m_tdata, m_tuser, m_tlast);
                fail_count++;
            end
            else begin
                want = due_beats.pop_front();
                if (m_tdata !== want.unit) begin
                    $error("out_code_unit: expected %h, got %h", want.unit, m_tdata);
                    fail_count++;
                end
                if (m_tuser !== want.valid) begin
                    $error("out_valid: expected %b, got %b", want.valid, m_tuser);
                    fail_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("out_last: expected %b, got %b", want.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Drivers. Both leave s_tvalid / cfg_valid high on return, so that a
    // following beat keeps it high with a single assignment per step; send_unit
    // lowers s_tvalid for an idle gap, else the caller lowers it when the stream pauses.
    // ------------------------------------------------------------------
    task automatic send_unit(logic [UW-1:0] u, bit last, bit typed = 1'b0,
                             stcf_pkg::res_t want = '0);
        int gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= u;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        clean_unit(u, last);
        // rows with a hand-typed result replace the predicted one
        if (typed)
            due_beats.push_back(want);
        else
            foreach (step_beats[i])
                due_beats.push_back(step_beats[i]);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [stcf_pkg::CFG_IDX_W-1:0] idx, bit val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            stcf_pkg::REG_REDUCE_LINE_BREAKS:    reduce_lb = val;
            stcf_pkg::REG_REMOVE_TRADEMARK_TAGS: strip_tm  = val;
            default: ;   // unused index, ignored
        endcase
        @(negedge clk);
    endtask

    // Stop input, wait for every due beat, then let the buffer go quiet.
    // Units that cause no beat may still be in flight, hence the extra cycles.
    task automatic settle();
        int waited = 0;
        s_tvalid <= 1'b0;
        while (due_beats.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge clk);
            waited++;
        end
        if (due_beats.size() != 0) begin
            $error("%0d result beats never arrived", due_beats.size());
            fail_count++;
            due_beats.delete();
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Random segments: mostly well-formed text with tags, line breaks and
    // odd units, plus broken tag openers and stray brackets.
    // ------------------------------------------------------------------
    logic [UW-1:0] seg_text[$];

    function automatic logic [UW-1:0] any_case(logic [UW-1:0] lo, logic [UW-1:0] up);
        return $urandom_range(0, 1) ? lo : up;
    endfunction

    function automatic void add_letters(int lo, int hi);
        int n = $urandom_range(lo, hi);
        repeat (n) seg_text.push_back(16'($urandom_range(8'h20, 8'h7E)));
    endfunction

    function automatic void build_segment();
        int pieces = $urandom_range(1, 5);
        for (int p = 0; p < pieces; p++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: add_letters(1, 4);
                3: seg_text.push_back(16'($urandom));            // full-width unit
                4: begin
                    case ($urandom_range(0, 2))
                        0: seg_text.push_back(U_CR);
                        1: seg_text.push_back(U_LF);
                        default: begin
                            seg_text.push_back(U_CR);
                            seg_text.push_back(U_LF);
                        end
                    endcase
                end
                5, 6: begin                                      // "<tm ...>", sometimes unclosed
                    seg_text.push_back(U_LT);
                    seg_text.push_back(any_case(U_TL, U_TU));
                    seg_text.push_back(any_case(U_ML, U_MU));
                    seg_text.push_back(U_SP);
                    add_letters(0, 3);
                    if ($urandom_range(0, 4) != 0)
                        seg_text.push_back(U_GT);
                end
                7: begin                                         // "</tm...>"
                    seg_text.push_back(U_LT);
                    seg_text.push_back(U_SL);
                    seg_text.push_back(any_case(U_TL, U_TU));
                    seg_text.push_back(any_case(U_ML, U_MU));
                    add_letters(0, 2);
                    seg_text.push_back(U_GT);
                end
                8: begin                                         // near misses
                    seg_text.push_back(U_LT);
                    case ($urandom_range(0, 3))
                        0: begin
                            seg_text.push_back(any_case(U_TL, U_TU));
                            seg_text.push_back(U_GT);
                        end
                        1: begin
                            seg_text.push_back(U_SL);
                            seg_text.push_back(any_case(U_ML, U_MU));
                            seg_text.push_back(any_case(U_TL, U_TU));
                        end
                        2: begin
                            // LF here turns into the space of "<tm " when reduced
                            seg_text.push_back(any_case(U_TL, U_TU));
                            seg_text.push_back(any_case(U_ML, U_MU));
                            seg_text.push_back(U_LF);
                        end
                        default: begin
                            seg_text.push_back(any_case(U_TL, U_TU));
                            seg_text.push_back(U_SP);
                        end
                    endcase
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0: seg_text.push_back(U_GT);
                        1: seg_text.push_back(U_LT);
                        2: seg_text.push_back(U_SL);
                        default: seg_text.push_back(any_case(U_TL, U_MU));
                    endcase
                end
            endcase
        end
    endfunction

    task automatic send_next();
        logic [UW-1:0] u;
        if (seg_text.size() == 0)
            build_segment();
        u = seg_text.pop_front();
        send_unit(u, seg_text.size() == 0);
    endtask

    // ------------------------------------------------------------------
    // Directed rows, all with both stages on (reset values).
    // ------------------------------------------------------------------
    typedef struct {
        logic [UW-1:0]  unit;
        bit             last;
        bit             typed;   // want holds the single beat this row causes
        stcf_pkg::res_t want;
    } dir_row_t;

    localparam int DIR_ROWS = 27;

    dir_row_t directed_rows [DIR_ROWS] = '{
        // one-unit segments: extremes pass untouched, zero is an ordinary unit
        '{16'h0041, 1'b1, 1'b1, '{16'h0041, 1'b1, 1'b1}},
        '{16'h0000, 1'b1, 1'b1, '{16'h0000, 1'b1, 1'b1}},
        '{16'hFFFF, 1'b1, 1'b1, '{16'hFFFF, 1'b1, 1'b1}},
        // CR, or an LF that ends the segment, leaves only a bare end marker
        '{U_CR,     1'b1, 1'b1, '{16'h0000, 1'b0, 1'b1}},
        '{U_LF,     1'b1, 1'b1, '{16'h0000, 1'b0, 1'b1}},
        // inner LF becomes a space
        '{16'h0061, 1'b0, 1'b0, '0},
        '{U_LF,     1'b0, 1'b0, '0},
        '{16'h0062, 1'b1, 1'b0, '0},
        // open tag dropped through '>'
        '{U_LT,     1'b0, 1'b0, '0},
        '{U_TL,     1'b0, 1'b0, '0},
        '{U_ML,     1'b0, 1'b0, '0},
        '{U_SP,     1'b0, 1'b0, '0},
        '{U_GT,     1'b0, 1'b0, '0},
        '{16'h0079, 1'b1, 1'b0, '0},
        // upper-case close tag whose '>' ends the segment
        '{U_LT,     1'b0, 1'b0, '0},
        '{U_SL,     1'b0, 1'b0, '0},
        '{U_TU,     1'b0, 1'b0, '0},
        '{U_MU,     1'b0, 1'b0, '0},
        '{U_GT,     1'b1, 1'b1, '{16'h0000, 1'b0, 1'b1}},
        // three units of an opener at the segment end are flushed
        '{U_LT,     1'b0, 1'b0, '0},
        '{U_TU,     1'b0, 1'b0, '0},
        '{U_ML,     1'b1, 1'b0, '0},
        // unclosed tag: skipping stops at the segment end
        '{U_LT,     1'b0, 1'b0, '0},
        '{U_TL,     1'b0, 1'b0, '0},
        '{U_MU,     1'b0, 1'b0, '0},
        '{U_SP,     1'b0, 1'b0, '0},
        '{16'h0071, 1'b1, 1'b1, '{16'h0000, 1'b0, 1'b1}}
    };

    // register settings per random phase; the last two are drawn at random
    bit plan_reduce [4] = '{1'b0, 1'b1, 1'b0, 1'b1};
    bit plan_strip  [4] = '{1'b1, 1'b0, 1'b0, 1'b1};

    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        m_tready   = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = stcf_pkg::REG_REDUCE_LINE_BREAKS;
        cfg_data   = 1'b0;
        ready_hold = 0;
        no_idle    = 1'b0;
        fail_count = 0;

        // predictor reset state matches the block's
        reduce_lb = 1'b1;
        strip_tm  = 1'b1;
        lf_held   = 1'b0;
        in_tag    = 1'b0;
        tag_fill  = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_unit(directed_rows[i].unit, directed_rows[i].last,
                      directed_rows[i].typed, directed_rows[i].want);

        // Random phases. A phase may stop inside a segment, so a register
        // change can land with units held in the tag window or an LF held.
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            write_reg(stcf_pkg::REG_REDUCE_LINE_BREAKS,
                      ph < 4 ? plan_reduce[ph] : 1'($urandom_range(0, 1)));
            write_reg(stcf_pkg::REG_REMOVE_TRADEMARK_TAGS,
                      ph < 4 ? plan_strip[ph] : 1'($urandom_range(0, 1)));
            write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                      1'($urandom_range(0, 1)));
            cfg_valid <= 1'b0;
            no_idle = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_next();
        end

        // close the segment still open
        while (seg_text.size() != 0)
            send_next();

        settle();
        if (fail_count == 0)
            $display("[segment_text_cleanup_filter_top] OK");
        else
            $display("[segment_text_cleanup_filter_top] ERROR");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("[segment_text_cleanup_filter_top] ERROR");
        $finish;
    end

endmodule
